// ----- hdl/avt_pkg.sv -----
package avt_pkg;

   localparam int ELEM_WIDTH          = 32;
   localparam int FIELD_WIDTH         = 32;
   localparam int FRAC_BITS           = 16;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int MATRIX_ROWS         = 4;
   localparam int MATRIX_COLS         = 3;
   localparam int NUM_WORDS           = 6;
   localparam int WORD_WIDTH          = 2 * ELEM_WIDTH;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int VEC_DATA_WIDTH      = MATRIX_COLS * FIELD_WIDTH;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_MATRIX_WORDS_0 = 3'd0;
   localparam csr_index_type CSR_MATRIX_WORDS_1 = 3'd1;
   localparam csr_index_type CSR_MATRIX_WORDS_2 = 3'd2;
   localparam csr_index_type CSR_MATRIX_WORDS_3 = 3'd3;
   localparam csr_index_type CSR_MATRIX_WORDS_4 = 3'd4;
   localparam csr_index_type CSR_MATRIX_WORDS_5 = 3'd5;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef elem_type [MATRIX_ROWS-1:0][MATRIX_COLS-1:0] matrix_type;

   localparam word_type IDENTITY_WORD = 64'h0000_0000_0001_0000;
   localparam word_type ZERO_WORD     = 64'h0000_0000_0000_0000;

   typedef struct packed {
      logic          wr_en;
      csr_index_type index;
      word_type      wdata;
   } csr_write_type;

endpackage

// ----- hdl/avt_matrix_regs.sv -----
module avt_matrix_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  avt_pkg::csr_write_type csr_write,
   output avt_pkg::matrix_type   matrix
);
   import avt_pkg::*;

   word_type words_ff [NUM_WORDS];
   word_type words_in [NUM_WORDS];

   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         words_in[i] = words_ff[i];
      end
      if (csr_write.wr_en) begin
         unique case (csr_write.index)
            CSR_MATRIX_WORDS_0: words_in[0] = csr_write.wdata;
            CSR_MATRIX_WORDS_1: words_in[1] = csr_write.wdata;
            CSR_MATRIX_WORDS_2: words_in[2] = csr_write.wdata;
            CSR_MATRIX_WORDS_3: words_in[3] = csr_write.wdata;
            CSR_MATRIX_WORDS_4: words_in[4] = csr_write.wdata;
            CSR_MATRIX_WORDS_5: words_in[5] = csr_write.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff[0] <= IDENTITY_WORD;
         words_ff[1] <= ZERO_WORD;
         words_ff[2] <= IDENTITY_WORD;
         words_ff[3] <= ZERO_WORD;
         words_ff[4] <= IDENTITY_WORD;
         words_ff[5] <= ZERO_WORD;
      end else begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_ff[i] <= words_in[i];
         end
      end
   end

   // element (r, c) sits in word (3r+c)/2, odd elements in the high half
   for (genvar r = 0; r < MATRIX_ROWS; r++) begin : g_row
      for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_col
         localparam int E = r * MATRIX_COLS + c;
         assign matrix[r][c] = words_ff[E / 2][(E % 2) * ELEM_WIDTH +: ELEM_WIDTH];
      end
   end

endmodule

// ----- hdl/avt_product_stage.sv -----
module avt_product_stage #(
   parameter int COORD_WIDTH = avt_pkg::COORD_WIDTH_DEFAULT,
   parameter int PROD_WIDTH  = avt_pkg::ELEM_WIDTH + COORD_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  avt_pkg::matrix_type                matrix,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_op,
   input  logic [avt_pkg::VEC_DATA_WIDTH-1:0] in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_op,
   output logic [9*PROD_WIDTH-1:0]            out_products
);
   import avt_pkg::*;

   logic                          vec_valid_ff;
   logic                          vec_op_ff;
   logic signed [COORD_WIDTH-1:0] vec_ff [MATRIX_COLS];
   logic                          vec_ready;

   logic                          prod_valid_ff;
   logic                          prod_op_ff;
   logic [9*PROD_WIDTH-1:0]       prod_ff;
   logic [9*PROD_WIDTH-1:0]       prod_in;

   assign vec_ready = !prod_valid_ff || out_ready;
   assign in_ready  = !vec_valid_ff || vec_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_valid_ff <= 1'b0;
      end else if (in_ready) begin
         vec_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         vec_op_ff <= in_op;
         for (int i = 0; i < MATRIX_COLS; i++) begin
            vec_ff[i] <= in_data[i*FIELD_WIDTH +: COORD_WIDTH];
         end
      end
   end

   // product (c, r) = m[r][c] * v[r]
   for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_col
      for (genvar r = 0; r < MATRIX_COLS; r++) begin : g_row
         assign prod_in[(c*MATRIX_COLS + r)*PROD_WIDTH +: PROD_WIDTH] =
            PROD_WIDTH'(PROD_WIDTH'(matrix[r][c]) * PROD_WIDTH'(vec_ff[r]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (vec_ready) begin
         prod_valid_ff <= vec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vec_valid_ff && vec_ready) begin
         prod_op_ff <= vec_op_ff;
         prod_ff    <= prod_in;
      end
   end

   assign out_valid    = prod_valid_ff;
   assign out_op       = prod_op_ff;
   assign out_products = prod_ff;

endmodule

// ----- hdl/avt_reduce_stage.sv -----
module avt_reduce_stage #(
   parameter int COORD_WIDTH = avt_pkg::COORD_WIDTH_DEFAULT,
   parameter int PROD_WIDTH  = avt_pkg::ELEM_WIDTH + COORD_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  avt_pkg::matrix_type                matrix,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_op,
   input  logic [9*PROD_WIDTH-1:0]            in_products,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_overflow,
   output logic [avt_pkg::VEC_DATA_WIDTH-1:0] out_data
);
   import avt_pkg::*;

   localparam int SUM_WIDTH = PROD_WIDTH + 2;
   localparam logic signed [SUM_WIDTH-1:0] MAX_VAL =
      SUM_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_WIDTH-1:0] MIN_VAL = -MAX_VAL - SUM_WIDTH'(1);

   logic                        res_valid_ff;
   logic                        res_ovf_ff;
   logic [VEC_DATA_WIDTH-1:0]   res_data_ff;
   logic                        res_ovf_in;
   logic [VEC_DATA_WIDTH-1:0]   res_data_in;
   logic [MATRIX_COLS-1:0]      comp_ovf;

   assign in_ready = !res_valid_ff || out_ready;

   for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_col
      logic signed [SUM_WIDTH-1:0]   sum;
      logic signed [SUM_WIDTH-1:0]   acc;
      logic signed [SUM_WIDTH-1:0]   trans;
      logic signed [COORD_WIDTH-1:0] sat;

      always_comb begin
         sum = '0;
         for (int r = 0; r < MATRIX_COLS; r++) begin
            sum = sum + SUM_WIDTH'($signed(
               in_products[(c*MATRIX_COLS + r)*PROD_WIDTH +: PROD_WIDTH]));
         end
         trans = in_op ? SUM_WIDTH'(matrix[MATRIX_ROWS-1][c]) : '0;
         acc   = (sum >>> FRAC_BITS) + trans;
         priority if (acc > MAX_VAL) begin
            sat         = COORD_WIDTH'(MAX_VAL);
            comp_ovf[c] = 1'b1;
         end else if (acc < MIN_VAL) begin
            sat         = COORD_WIDTH'(MIN_VAL);
            comp_ovf[c] = 1'b1;
         end else begin
            sat         = COORD_WIDTH'(acc);
            comp_ovf[c] = 1'b0;
         end
      end

      assign res_data_in[c*FIELD_WIDTH +: FIELD_WIDTH] = FIELD_WIDTH'(sat);
   end

   assign res_ovf_in = |comp_ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (in_ready) begin
         res_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ovf_ff  <= res_ovf_in;
         res_data_ff <= res_data_in;
      end
   end

   assign out_valid    = res_valid_ff;
   assign out_overflow = res_ovf_ff;
   assign out_data     = res_data_ff;

endmodule

// ----- hdl/affine_vector_transform_core.sv -----
// channel   direction  handshake              tdata (low to high)          tuser
// req_      in         req_tvalid/req_tready  x_in, y_in, z_in (32 each)   op
// rsp_      out        rsp_tvalid/rsp_tready  x_out, y_out, z_out (32 each) overflow
// csr_      in         csr_wr_en              csr_wdata 64, csr_index 3    -
//
// one word accepted per cycle unless a stall on rsp_ holds the pipe; three register stages: input, products, result
// a word passes the input, products and result registers in turn before its result is valid
// stalls on rsp_ ripple back stage by stage, empty stages keep filling
// synchronous reset empties the pipe and loads the identity matrix
module affine_vector_transform_core #(
   parameter int COORD_WIDTH = avt_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [avt_pkg::VEC_DATA_WIDTH-1:0]  req_tdata,  // x_in, y_in, z_in
   input  logic                                req_tuser,  // op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [avt_pkg::VEC_DATA_WIDTH-1:0]  rsp_tdata,  // x_out, y_out, z_out
   output logic                                rsp_tuser,  // overflow
   input  logic                                csr_wr_en,
   input  logic [avt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [avt_pkg::WORD_WIDTH-1:0]      csr_wdata
);
   import avt_pkg::*;

   localparam int PROD_WIDTH = ELEM_WIDTH + COORD_WIDTH;

   csr_write_type           csr_write;
   matrix_type              matrix;
   logic                    prod_valid;
   logic                    prod_ready;
   logic                    prod_op;
   logic [9*PROD_WIDTH-1:0] products;

   assign csr_write.wr_en = csr_wr_en;
   assign csr_write.index = csr_index;
   assign csr_write.wdata = csr_wdata;

   avt_matrix_regs u_matrix_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .matrix    (matrix)
   );

   avt_product_stage #(
      .COORD_WIDTH (COORD_WIDTH),
      .PROD_WIDTH  (PROD_WIDTH)
   ) u_product_stage (
      .clock        (clock),
      .reset        (reset),
      .matrix       (matrix),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_op        (req_tuser),
      .in_data      (req_tdata),
      .out_valid    (prod_valid),
      .out_ready    (prod_ready),
      .out_op       (prod_op),
      .out_products (products)
   );

   avt_reduce_stage #(
      .COORD_WIDTH (COORD_WIDTH),
      .PROD_WIDTH  (PROD_WIDTH)
   ) u_reduce_stage (
      .clock        (clock),
      .reset        (reset),
      .matrix       (matrix),
      .in_valid     (prod_valid),
      .in_ready     (prod_ready),
      .in_op        (prod_op),
      .in_products  (products),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_overflow (rsp_tuser),
      .out_data     (rsp_tdata)
   );

endmodule
